// File: sv/cma_pkg.sv
`default_nettype none

package cma_pkg;

    // Length of the averaging window, from 2 to 256 entries.
    localparam int WINDOW_LEN = 16;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int DIV_W      = $clog2(WINDOW_LEN + 1);

    // Field and datapath widths.
    localparam int SMP_W      = 16;
    localparam int VAL_W      = 32;
    localparam int FLOOR_W    = 31;
    localparam int PROD_W     = 48;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = $clog2(SUM_W);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLED = 2'd0,
        CFG_GAIN    = 2'd1,
        CFG_OFFSET  = 2'd2,
        CFG_FLOOR   = 2'd3
    } t_cfg_reg;

    // Item kinds carried on the input tuser.
    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_CLEAR  = 1'b1
    } t_mode;

    // Saturation limits.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: sv/calibrated_moving_average.sv
`default_nettype none

// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata tuser        raw_sample; mode
// m_axis    out        tvalid tready tdata tuser        value; updated
// cfg       in         i_cfg_we i_cfg_addr i_cfg_data   enabled, gain, offset, floor_offset
//
// A sample that enters the ring passes through one multiply, four add or subtract steps and
// a restoring divider that retires one quotient bit per cycle before its result is loaded
// into the output register; the next input transfer can follow in the cycle after that load.
// Clear items, negative samples and items seen while disabled go straight to the output
// register without entering the ring. Reset is synchronous and active low; it clears
// the configuration, the running sum, the write index and the full flag. s_axis_tready is
// high only while no item is in work; a result held on m_axis may wait while the next
// item is taken in, and a stalled output register holds the block in its last state.
module calibrated_moving_average
    import cma_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Input stream.
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [TDATA_IN_W-1:0]   s_axis_tdata,   // [15:0] raw_sample
    input  wire  [0:0]              s_axis_tuser,   // [0] mode
    // Output stream.
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [TDATA_OUT_W-1:0]  m_axis_tdata,   // [31:0] value
    output logic [0:0]              m_axis_tuser,   // [0] updated
    // Configuration writes.
    input  wire                     i_cfg_we,
    input  wire  [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_CAL  = 10'b0000000100,
        S_SUB  = 10'b0000001000,
        S_ADD  = 10'b0000010000,
        S_ABS  = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_FIN  = 10'b0010000000,
        S_RES  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;

    // Configuration registers.
    logic                       r_enabled;
    logic signed [VAL_W-1:0]    r_gain;
    logic signed [VAL_W-1:0]    r_offset;
    logic [FLOOR_W-1:0]         r_floor;

    // Averaging state.
    logic signed [SUM_W-1:0]    r_sum;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_full;

    // Per-item working registers.
    logic signed [SMP_W-1:0]    r_raw;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [VAL_W-1:0]    r_entry;
    logic [DIV_W-1:0]           r_div;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_quo;
    logic [DIV_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [SUM_W:0]      r_avg;
    logic signed [VAL_W-1:0]    r_res;
    logic                       r_upd;

    // Output register.
    logic                       r_out_valid;
    logic [VAL_W-1:0]           r_out_value;
    logic                       r_out_upd;

    logic                       in_xfer;
    logic                       out_load;
    logic [VAL_W-1:0]           ram_rdata;
    logic signed [VAL_W-1:0]    old_entry;

    logic signed [PROD_W:0]     cal_wide;
    logic signed [VAL_W-1:0]    cal_sat;
    logic signed [SUM_W:0]      sub_wide;
    logic signed [SUM_W-1:0]    sub_sat;
    logic signed [SUM_W-1:0]    sub_clamp;
    logic signed [SUM_W:0]      add_wide;
    logic signed [SUM_W-1:0]    add_sat;
    logic [DIV_W:0]             trial;
    logic                       trial_ge;
    logic signed [SUM_W+1:0]    res_wide;
    logic signed [VAL_W-1:0]    res_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign old_entry     = $signed(ram_rdata);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_upd;

    // Ring storage; the read address follows the write index so the registered read always
    // holds the entry to be replaced once the index has settled.
    cma_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ADD),
        .i_waddr (r_idx),
        .i_wdata (r_entry),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Calibration: product plus intercept, saturated to 32 bits.
    always_comb begin
        cal_wide = $signed({r_prod[PROD_W-1], r_prod})
                 + $signed({{(PROD_W+1-VAL_W){r_offset[VAL_W-1]}}, r_offset});
        if ((&cal_wide[PROD_W:VAL_W-1]) || !(|cal_wide[PROD_W:VAL_W-1])) begin
            cal_sat = cal_wide[VAL_W-1:0];
        end else begin
            cal_sat = cal_wide[PROD_W] ? VAL_MIN : VAL_MAX;
        end
    end

    // Removal of the oldest entry once the ring is full, then clamp at zero.
    always_comb begin
        sub_wide = $signed({r_sum[SUM_W-1], r_sum})
                 - $signed({{(SUM_W+1-VAL_W){old_entry[VAL_W-1]}}, old_entry});
        if (sub_wide[SUM_W] == sub_wide[SUM_W-1]) begin
            sub_sat = sub_wide[SUM_W-1:0];
        end else begin
            sub_sat = sub_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        sub_clamp = r_full ? sub_sat : r_sum;
        if (sub_clamp[SUM_W-1]) begin
            sub_clamp = '0;
        end
    end

    // Addition of the new entry to the running sum.
    always_comb begin
        add_wide = $signed({r_sum[SUM_W-1], r_sum})
                 + $signed({{(SUM_W+1-VAL_W){r_entry[VAL_W-1]}}, r_entry});
        if (add_wide[SUM_W] == add_wide[SUM_W-1]) begin
            add_sat = add_wide[SUM_W-1:0];
        end else begin
            add_sat = add_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
    end

    // One restoring division step.
    always_comb begin
        trial    = {r_rem, r_quo[SUM_W-1]};
        trial_ge = (trial >= {1'b0, r_div});
    end

    // Floor subtraction, saturated to 32 bits.
    always_comb begin
        res_wide = $signed({r_avg[SUM_W], r_avg})
                 - $signed({{(SUM_W+2-FLOOR_W){1'b0}}, r_floor});
        if ((&res_wide[SUM_W+1:VAL_W-1]) || !(|res_wide[SUM_W+1:VAL_W-1])) begin
            res_sat = res_wide[VAL_W-1:0];
        end else begin
            res_sat = res_wide[SUM_W+1] ? VAL_MIN : VAL_MAX;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((s_axis_tuser[0] == MODE_CLEAR) || !r_enabled
                        || s_axis_tdata[SMP_W-1]) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: n_state = S_CAL;
            S_CAL: n_state = S_SUB;
            S_SUB: n_state = S_ADD;
            S_ADD: n_state = S_ABS;
            S_ABS: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_RES;
            S_RES: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and averaging state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_gain      <= '0;
            r_offset    <= '0;
            r_floor     <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_ENABLED: r_enabled <= i_cfg_data[0];
                    CFG_GAIN:    r_gain    <= $signed(i_cfg_data);
                    CFG_OFFSET:  r_offset  <= $signed(i_cfg_data);
                    CFG_FLOOR:   r_floor   <= i_cfg_data[FLOOR_W-1:0];
                    default:     r_enabled <= r_enabled;
                endcase
            end

            // A clear only empties the bookkeeping: stale ring words are never subtracted from the sum
            // because the full flag stays low until every entry is rewritten.
            if (in_xfer && (s_axis_tuser[0] == MODE_CLEAR) && r_enabled) begin
                r_sum  <= '0;
                r_idx  <= '0;
                r_full <= 1'b0;
            end

            if (r_state == S_SUB) begin
                r_sum <= sub_clamp;
            end
            if (r_state == S_ADD) begin
                r_sum <= add_sat;
            end

            // Advance the write index once the result is known.
            if (r_state == S_FIN) begin
                if (r_idx == IDX_W'(WINDOW_LEN - 1)) begin
                    r_idx  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_raw <= $signed(s_axis_tdata[SMP_W-1:0]);
                r_res <= '0;
                r_upd <= 1'b0;
            end
            S_MUL: r_prod <= r_gain * r_raw;
            S_CAL: r_entry <= cal_sat;
            S_ADD: r_div <= r_full ? DIV_W'(WINDOW_LEN) : (DIV_W'(r_idx) + 1'b1);
            S_ABS: begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
                r_rem <= '0;
                r_cnt <= CNT_W'(SUM_W - 1);
            end
            S_DIV: begin
                r_rem <= trial_ge ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], trial_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                r_avg <= r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
            end
            S_RES: begin
                r_res <= res_sat;
                r_upd <= 1'b1;
            end
            S_OUT: begin
                if (out_load) begin
                    r_out_value <= r_res;
                    r_out_upd   <= r_upd;
                end
            end
            default: r_upd <= r_upd;
        endcase
    end

`ifndef SYNTHESIS
    // A clear transfer taken while enabled leaves an empty ring behind.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(in_xfer) && $past(s_axis_tuser[0] == MODE_CLEAR)
            && $past(r_enabled)) |-> (r_idx == '0) && !r_full && (r_sum == '0))
        else $error("clear transfer did not empty the averaging state");

    // A result that did not enter the ring always carries a zero value.
    a_zero_when_skipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("non-updating result carries a non-zero value");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divider running with a zero divisor");

    // The running sum is never negative before the new entry is added.
    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> !r_sum[SUM_W-1])
        else $error("running sum negative after removal step");
`endif

endmodule

`default_nettype wire

// File: sv/cma_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module cma_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire  [$clog2(DEPTH)-1:0]    i_waddr,
    input  wire  [DATA_W-1:0]           i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [DATA_W-1:0]           o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
